// File: rtl/uvt_pkg.sv
// shared types and codes for the unique value table
`default_nettype none

package uvt_pkg;

  typedef enum logic [2:0] {
    MODE_APPEND = 3'd0,
    MODE_INSERT = 3'd1,
    MODE_DELETE = 3'd2,
    MODE_DEDUP  = 3'd3,
    MODE_COUNT  = 3'd4,
    MODE_READ   = 3'd5
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PRESENT = 2'd1,
    ST_FULL    = 2'd2,
    ST_RANGE   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DEL,
    S_READ_WAIT,
    S_DD_CAP,
    S_DD_SCAN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [31:0] value;
    logic [5:0]         index;
  } req_t;

  typedef struct packed {
    logic signed [31:0] data;
    logic [6:0]         occurrences;
    logic [6:0]         length;
    logic [1:0]         status;
  } rsp_t;

endpackage

`default_nettype wire

// File: rtl/uvt_mem.sv
// table storage: one write port, one registered read port
`default_nettype none

module uvt_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] ram [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      ram[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= ram[raddr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/uvt_ctrl.sv
// sequencer: appends, reads, scans, shifts and compacts the table through the memory
`default_nettype none

module uvt_ctrl #(
  parameter int DEPTH      = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          req_valid,
  output logic                               req_stall,
  input  wire uvt_pkg::req_t                 req,
  output logic                               res_valid,
  input  wire logic                          res_free,
  output uvt_pkg::rsp_t                      res,
  output logic                               mem_we,
  output logic [$clog2(DEPTH)-1:0]           mem_waddr,
  output logic [VALUE_BITS-1:0]              mem_wdata,
  output logic                               mem_re,
  output logic [$clog2(DEPTH)-1:0]           mem_raddr,
  input  wire logic [VALUE_BITS-1:0]         mem_rdata
);

  import uvt_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > 6) ? CW : 6;
  localparam int OW = (CW > 7) ? CW : 7;

  state_t              state, state_next;
  logic [CW-1:0]       used, used_next;
  logic [CW-1:0]       ptr, ptr_next;
  logic                pend, pend_next;
  logic [AW-1:0]       ra, ra_next;
  logic [CW-1:0]       cnt, cnt_next;
  logic [CW-1:0]       rr, rr_next;
  logic [CW-1:0]       ww, ww_next;
  logic [VALUE_BITS-1:0] cur, cur_next;
  logic [VALUE_BITS-1:0] val, val_next;
  logic [2:0]          mode, mode_next;
  logic [1:0]          status, status_next;
  logic [31:0]         data, data_next;

  logic signed [63:0]  in_ext;
  logic signed [63:0]  rd_ext;
  logic [XW-1:0]       idx_x, used_x, idx_inc;
  logic [CW-1:0]       rr_inc, ww_inc;
  logic                full, hit_val, hit_cur, more;
  logic [OW-1:0]       cnt_ext, used_ext;

  assign in_ext  = 64'(req.value);
  assign rd_ext  = 64'($signed(mem_rdata));
  assign idx_x   = XW'(req.index);
  assign used_x  = XW'(used);
  assign idx_inc = idx_x + XW'(1);
  assign rr_inc  = rr + CW'(1);
  assign ww_inc  = ww + CW'(1);
  assign full    = (used == CW'(DEPTH));
  assign hit_val = pend && (mem_rdata == val);
  assign hit_cur = pend && (mem_rdata == cur);
  assign more    = (ptr < used);
  assign cnt_ext = OW'(cnt);
  assign used_ext = OW'(used);

  assign req_stall = (state != S_IDLE);
  assign res_valid = (state == S_FINISH);

  always_comb begin
    res.data        = data;
    res.occurrences = (mode == MODE_COUNT) ? cnt_ext[6:0] : 7'd0;
    res.length      = used_ext[6:0];
    res.status      = status;
  end

  always_comb begin
    state_next  = state;
    used_next   = used;
    ptr_next    = ptr;
    pend_next   = pend;
    ra_next     = ra;
    cnt_next    = cnt;
    rr_next     = rr;
    ww_next     = ww;
    cur_next    = cur;
    val_next    = val;
    mode_next   = mode;
    status_next = status;
    data_next   = data;
    mem_we      = 1'b0;
    mem_waddr   = used[AW-1:0];
    mem_wdata   = val;
    mem_re      = 1'b0;
    mem_raddr   = ptr[AW-1:0];

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          val_next    = in_ext[VALUE_BITS-1:0];
          mode_next   = req.mode;
          status_next = ST_OK;
          data_next   = '0;
          cnt_next    = '0;
          ptr_next    = '0;
          pend_next   = 1'b0;
          state_next  = S_FINISH;
          case (req.mode)
            MODE_APPEND: begin
              if (full) begin
                status_next = ST_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = used[AW-1:0];
                mem_wdata = in_ext[VALUE_BITS-1:0];
                used_next = used + CW'(1);
              end
            end
            MODE_INSERT, MODE_COUNT: begin
              state_next = S_SCAN;
            end
            MODE_DELETE: begin
              if (idx_x >= used_x) begin
                status_next = ST_RANGE;
              end else begin
                ptr_next   = CW'(idx_inc);
                state_next = S_DEL;
              end
            end
            MODE_DEDUP: begin
              rr_next = '0;
              ww_next = '0;
              if (used != '0) begin
                mem_re     = 1'b1;
                mem_raddr  = '0;
                state_next = S_DD_CAP;
              end
            end
            MODE_READ: begin
              if (idx_x >= used_x) begin
                status_next = ST_RANGE;
              end else begin
                mem_re     = 1'b1;
                mem_raddr  = AW'(idx_x);
                state_next = S_READ_WAIT;
              end
            end
            default: begin
              state_next = S_FINISH;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (hit_val) begin
          cnt_next = cnt + CW'(1);
        end
        if (more) begin
          mem_re    = 1'b1;
          mem_raddr = ptr[AW-1:0];
          ptr_next  = ptr + CW'(1);
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
        end
        if (!pend && !more) begin
          state_next = S_FINISH;
          if (mode == MODE_INSERT) begin
            if (cnt != '0) begin
              status_next = ST_PRESENT;
            end else if (full) begin
              status_next = ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = used[AW-1:0];
              mem_wdata = val;
              used_next = used + CW'(1);
            end
          end
        end
      end

      S_DEL: begin
        // data read from ra moves down one place
        if (pend) begin
          mem_we    = 1'b1;
          mem_waddr = ra - AW'(1);
          mem_wdata = mem_rdata;
        end
        if (more) begin
          mem_re    = 1'b1;
          mem_raddr = ptr[AW-1:0];
          ra_next   = ptr[AW-1:0];
          ptr_next  = ptr + CW'(1);
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
        end
        if (!pend && !more) begin
          used_next  = used - CW'(1);
          state_next = S_FINISH;
        end
      end

      S_READ_WAIT: begin
        data_next  = rd_ext[31:0];
        state_next = S_FINISH;
      end

      S_DD_CAP: begin
        cur_next   = mem_rdata;
        ptr_next   = rr_inc;
        pend_next  = 1'b0;
        state_next = S_DD_SCAN;
      end

      S_DD_SCAN: begin
        if (more) begin
          mem_re    = 1'b1;
          mem_raddr = ptr[AW-1:0];
          ptr_next  = ptr + CW'(1);
          pend_next = 1'b1;
        end else begin
          pend_next = 1'b0;
        end
        // a later copy exists, or the scan ran out without one
        if (hit_cur || (!pend && !more)) begin
          if (!hit_cur) begin
            mem_we    = 1'b1;
            mem_waddr = ww[AW-1:0];
            mem_wdata = cur;
            ww_next   = ww_inc;
          end
          rr_next = rr_inc;
          if (rr_inc < used) begin
            mem_re     = 1'b1;
            mem_raddr  = rr_inc[AW-1:0];
            state_next = S_DD_CAP;
          end else begin
            used_next  = hit_cur ? ww : ww_inc;
            state_next = S_FINISH;
          end
        end
      end

      S_FINISH: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      used  <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      used  <= used_next;
      pend  <= pend_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr    <= ptr_next;
    ra     <= ra_next;
    cnt    <= cnt_next;
    rr     <= rr_next;
    ww     <= ww_next;
    cur    <= cur_next;
    val    <= val_next;
    mode   <= mode_next;
    status <= status_next;
    data   <= data_next;
  end

endmodule

`default_nettype wire

// File: rtl/unique_value_table_core.sv
// top level of the unique value table: sequencer, table memory, result register
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+---------------------------
//   request | req_valid | req_stall | req (mode, value, index)
//   result  | rsp_valid | rsp_stall | rsp (data, occurrences, length, status)
//
// one operation at a time; the cost is set by the single memory read port,
// one table entry per cycle: insert and count scan the whole table, delete
// moves each entry above the index down one place, and dedupe scans past each
// entry r up to a later copy of it and keeps r only when none is found;
// append, read and the unused modes touch a single entry or none
// reset clears the length and control only; table contents need no clearing
// a new request transfer is taken while the previous result still waits;
// a stalled result holds the sequencer in its finish step
`default_nettype none

module unique_value_table_core #(
  parameter int DEPTH      = 64,
  parameter int VALUE_BITS = 32
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           req_valid,
  output logic                req_stall,
  input  wire uvt_pkg::req_t  req,
  output logic                rsp_valid,
  input  wire logic           rsp_stall,
  output uvt_pkg::rsp_t       rsp
);

  import uvt_pkg::*;

  localparam int AW = $clog2(DEPTH);

  // result handoff from the sequencer
  logic  res_valid;
  logic  res_free;
  rsp_t  res;

  // memory port wiring
  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [VALUE_BITS-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [VALUE_BITS-1:0] mem_rdata;

  // the result register frees up when empty or when its transfer completes
  assign res_free = !rsp_valid || !rsp_stall;

  uvt_ctrl #(
    .DEPTH      (DEPTH),
    .VALUE_BITS (VALUE_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .res_valid (res_valid),
    .res_free  (res_free),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  uvt_mem #(
    .DEPTH (DEPTH),
    .WIDTH (VALUE_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // output register: valid is a flop, so rsp_valid has no combinational path from rsp_stall
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_valid && res_free) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  // payload loads only when the slot is free, so a stalled result holds
  always_ff @(posedge clk) begin
    if (res_valid && res_free) begin
      rsp <= res;
    end
  end

endmodule

`default_nettype wire

// File: bench/unique_value_table_core_test.sv
// testbench for the unique value table core: directed and random operations checked per transfer
`timescale 1ns / 100ps

module unique_value_table_core_test;
  import uvt_pkg::*;

  localparam int     TABLE_DEPTH     = 64;
  localparam int     RANDOM_ITEMS    = 1900;
  // the limit covers the worst item, a dedupe of a full table of distinct values,
  // plus the longest receiver stall and sender gap, over every item, times four
  localparam longint CYCLE_LIMIT     = 20_000_000;
  localparam int     SETTLE_CYCLES   = 40;
  localparam int     HOLD_OFF_CYCLES = 600;
  localparam int     HOLD_OFF_AFTER  = 300;
  localparam int     REPORT_LIMIT    = 10;

  // mode codes the block treats as no operation
  localparam logic [2:0] MODE_SPARE_6 = 3'd6;
  localparam logic [2:0] MODE_SPARE_7 = 3'd7;

  localparam logic signed [31:0] VALUE_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] VALUE_MAX = 32'sh7fff_ffff;
  localparam logic signed [31:0] CORNER_VALUES [5] =
    '{32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000, 32'shffff_ffff, 32'sh0000_0001};

  typedef enum int {EP_FILL, EP_DRAIN, EP_MIXED} episode_t;
  typedef enum int {STALL_NONE, STALL_SPARSE, STALL_PERIODIC, STALL_HEAVY} stall_style_t;

  // tracks the table contents and holds the results still owed by the block
  class table_tracker;
    logic signed [31:0] cells [TABLE_DEPTH];
    int                 fill = 0;
    rsp_t               awaited [$];
    int unsigned        mismatches = 0;
    int unsigned        results_seen = 0;
    int unsigned        mode_hits [8];
    int unsigned        status_hits [4];

    function int matches_of(logic signed [31:0] v);
      int i;
      int c;
      c = 0;
      for (i = 0; i < fill; i++)
        if (cells[i] == v) c++;
      return c;
    endfunction

    // apply one accepted request and queue the result it must produce
    function void note_request(req_t r);
      rsp_t exp_rsp;
      int   i;
      int   k;
      int   w;
      bit   later;
      exp_rsp = '0;
      exp_rsp.status = ST_OK;
      case (r.mode)
        MODE_APPEND: begin
          if (fill >= TABLE_DEPTH) exp_rsp.status = ST_FULL;
          else begin
            cells[fill] = r.value;
            fill++;
          end
        end
        MODE_INSERT: begin
          // presence wins over fullness
          if (matches_of(r.value) != 0) exp_rsp.status = ST_PRESENT;
          else if (fill >= TABLE_DEPTH) exp_rsp.status = ST_FULL;
          else begin
            cells[fill] = r.value;
            fill++;
          end
        end
        MODE_DELETE: begin
          if (r.index >= fill) exp_rsp.status = ST_RANGE;
          else begin
            for (i = r.index; i + 1 < fill; i++) cells[i] = cells[i + 1];
            fill--;
          end
        end
        MODE_DEDUP: begin
          // an entry survives only if no later entry holds the same value
          w = 0;
          for (i = 0; i < fill; i++) begin
            later = 1'b0;
            for (k = i + 1; k < fill; k++)
              if (cells[k] == cells[i]) later = 1'b1;
            if (!later) begin
              cells[w] = cells[i];
              w++;
            end
          end
          fill = w;
        end
        MODE_COUNT: exp_rsp.occurrences = 7'(matches_of(r.value));
        MODE_READ: begin
          if (r.index >= fill) exp_rsp.status = ST_RANGE;
          else exp_rsp.data = cells[r.index];
        end
        default: ;
      endcase
      exp_rsp.length = 7'(fill);
      mode_hits[r.mode]++;
      status_hits[exp_rsp.status]++;
      awaited.push_back(exp_rsp);
    endfunction

    function void check_result(rsp_t got);
      rsp_t want;
      results_seen++;
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("unexpected result transfer: data %h occ %0d len %0d status %0d",
                   got.data, got.occurrences, got.length, got.status);
        return;
      end
      want = awaited.pop_front();
      if (got.data !== want.data || got.occurrences !== want.occurrences ||
          got.length !== want.length || got.status !== want.status) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display({"result %0d mismatch: expected data %h occ %0d len %0d status %0d,",
                    " got data %h occ %0d len %0d status %0d"},
                   results_seen, want.data, want.occurrences, want.length, want.status,
                   got.data, got.occurrences, got.length, got.status);
      end
    endfunction
  endclass

  logic clk;
  logic rst       = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  req_t req       = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  table_tracker       tracker;
  int                 burst_left = 0;
  int                 items_sent = 0;
  longint             cycle_count = 0;
  logic signed [31:0] value_pool [8];
  int                 pool_size = 1;

  unique_value_table_core #(
    .DEPTH      (TABLE_DEPTH),
    .VALUE_BITS (32)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic req_t make_req(logic [2:0] m, logic signed [31:0] v, logic [5:0] ix);
    req_t r;
    r.mode  = m;
    r.value = v;
    r.index = ix;
    return r;
  endfunction

  // mostly pool values so duplicates are common, some table hits, corners and noise
  function automatic logic signed [31:0] pick_value();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 12) return value_pool[$urandom_range(0, pool_size - 1)];
    if (sel < 15 && tracker.fill != 0) return tracker.cells[$urandom_range(0, tracker.fill - 1)];
    if (sel < 17) return CORNER_VALUES[$urandom_range(0, 4)];
    return $urandom();
  endfunction

  // mostly a live position, sometimes any index at all
  function automatic logic [5:0] pick_index();
    if (tracker.fill != 0 && $urandom_range(0, 7) != 0)
      return 6'($urandom_range(0, tracker.fill - 1));
    return 6'($urandom());
  endfunction

  // offer one request, in bursts with random gaps, and wait for its transfer
  task automatic send_request(input req_t r);
    int gap;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    tracker.note_request(r);
    items_sent++;
  endtask

  // result side: check every transfer, stall on a drifting pattern, one long hold-off
  initial begin : result_sink
    stall_style_t style;
    int           style_left;
    int           hold_left;
    bit           held;
    style      = STALL_NONE;
    style_left = 0;
    hold_left  = 0;
    held       = 1'b0;
    forever begin
      @(posedge clk);
      if (rsp_valid && !rsp_stall) tracker.check_result(rsp);
      if (!held && tracker.results_seen >= HOLD_OFF_AFTER) begin
        held      = 1'b1;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (style_left == 0) begin
        style      = stall_style_t'($urandom_range(0, 3));
        style_left = $urandom_range(50, 400);
      end
      style_left--;
      if (hold_left > 0) begin
        // long hold-off so the block backs up into its request side
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        case (style)
          STALL_NONE:     rsp_stall <= 1'b0;
          STALL_SPARSE:   rsp_stall <= ($urandom_range(0, 3) == 0);
          STALL_PERIODIC: rsp_stall <= ((style_left % 7) < 3);
          default:        rsp_stall <= ($urandom_range(0, 1) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("run stopped at the cycle limit of %0d", CYCLE_LIMIT);
    $display("Test completed with failures");
    $finish;
  end

  initial begin : stimulus
    episode_t kind;
    int       random_start;
    int       i;
    int       n;
    int       pick;
    tracker = new;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty table: every index is out of range
    send_request(make_req(MODE_READ, 32'sd0, 6'd0));
    send_request(make_req(MODE_DELETE, VALUE_MAX, 6'd63));
    send_request(make_req(MODE_DEDUP, 32'sd0, 6'd0));
    send_request(make_req(MODE_COUNT, 32'sd0, 6'd0));
    // load the extremes, the minimum twice
    send_request(make_req(MODE_APPEND, VALUE_MIN, 6'd63));
    send_request(make_req(MODE_APPEND, VALUE_MAX, 6'd0));
    send_request(make_req(MODE_APPEND, 32'sd0, 6'd0));
    send_request(make_req(MODE_APPEND, -32'sd1, 6'd0));
    send_request(make_req(MODE_APPEND, VALUE_MIN, 6'd0));
    // insert of a present value, then of an absent one
    send_request(make_req(MODE_INSERT, VALUE_MAX, 6'd0));
    send_request(make_req(MODE_INSERT, 32'sh1234_5678, 6'd0));
    send_request(make_req(MODE_COUNT, VALUE_MIN, 6'd0));
    send_request(make_req(MODE_READ, 32'sd0, 6'd4));
    send_request(make_req(MODE_READ, 32'sd0, 6'd63));
    // index equal to the length
    send_request(make_req(MODE_DELETE, 32'sd0, 6'd6));
    // keeps the last copy of the minimum
    send_request(make_req(MODE_DEDUP, VALUE_MIN, 6'd63));
    send_request(make_req(MODE_READ, 32'sd0, 6'd0));
    send_request(make_req(MODE_DELETE, 32'sd0, 6'd0));
    send_request(make_req(MODE_DELETE, 32'sd0, 6'd3));
    send_request(make_req(MODE_SPARE_6, VALUE_MAX, 6'd5));
    send_request(make_req(MODE_SPARE_7, -32'sd1, 6'h3f));
    send_request(make_req(MODE_COUNT, -32'sd1, 6'd0));

    // random episodes, opening with a full table so overflow comes early
    random_start = items_sent;
    kind = EP_FILL;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      pool_size = $urandom_range(1, 8);
      for (i = 0; i < pool_size; i++)
        value_pool[i] = ($urandom_range(0, 3) == 0) ? CORNER_VALUES[$urandom_range(0, 4)]
                                                    : $urandom();
      case (kind)
        EP_FILL: begin
          while (tracker.fill < TABLE_DEPTH)
            send_request(make_req(MODE_APPEND, pick_value(), 6'($urandom())));
          n = $urandom_range(2, 6);
          for (i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
              0: send_request(make_req(MODE_APPEND, pick_value(), 6'($urandom())));
              1: send_request(make_req(MODE_INSERT, $urandom(), 6'($urandom())));
              2: send_request(make_req(MODE_INSERT,
                                       tracker.cells[$urandom_range(0, TABLE_DEPTH - 1)],
                                       6'($urandom())));
              default: send_request(make_req(MODE_READ, $urandom(), pick_index()));
            endcase
          end
        end
        EP_DRAIN: begin
          while (tracker.fill > 0)
            send_request(make_req(MODE_DELETE, $urandom(), pick_index()));
          n = $urandom_range(1, 3);
          for (i = 0; i < n; i++)
            send_request(make_req(($urandom_range(0, 1) == 0) ? MODE_READ : MODE_DELETE,
                                  $urandom(), 6'($urandom())));
        end
        default: begin
          n = $urandom_range(20, 80);
          for (i = 0; i < n; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
              send_request(make_req(MODE_APPEND, pick_value(), 6'($urandom())));
            else if (pick < 42)
              send_request(make_req(MODE_INSERT, pick_value(), 6'($urandom())));
            else if (pick < 56)
              send_request(make_req(MODE_DELETE, $urandom(), pick_index()));
            else if (pick < 59)
              send_request(make_req(MODE_DEDUP, $urandom(), 6'($urandom())));
            else if (pick < 75)
              send_request(make_req(MODE_COUNT, pick_value(), 6'($urandom())));
            else if (pick < 98)
              send_request(make_req(MODE_READ, $urandom(), pick_index()));
            else
              send_request(make_req(($urandom_range(0, 1) == 0) ? MODE_SPARE_6 : MODE_SPARE_7,
                                    $urandom(), 6'($urandom())));
          end
        end
      endcase
      pick = $urandom_range(0, 19);
      kind = (pick < 3) ? EP_FILL : (pick < 6) ? EP_DRAIN : EP_MIXED;
    end
    req_valid <= 1'b0;

    // drain the owed results, then watch for strays
    while (tracker.awaited.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display({"%0d transfers: append %0d, insert %0d, delete %0d, dedupe %0d,",
              " count %0d, read %0d, spare %0d"},
             items_sent, tracker.mode_hits[MODE_APPEND], tracker.mode_hits[MODE_INSERT],
             tracker.mode_hits[MODE_DELETE], tracker.mode_hits[MODE_DEDUP],
             tracker.mode_hits[MODE_COUNT], tracker.mode_hits[MODE_READ],
             tracker.mode_hits[MODE_SPARE_6] + tracker.mode_hits[MODE_SPARE_7]);
    $display({"outcomes: ok %0d, present %0d, full %0d, out of range %0d;",
              " %0d results, %0d mismatches"},
             tracker.status_hits[ST_OK], tracker.status_hits[ST_PRESENT],
             tracker.status_hits[ST_FULL], tracker.status_hits[ST_RANGE],
             tracker.results_seen, tracker.mismatches);
    if (tracker.mismatches == 0 && tracker.awaited.size() == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

endmodule
